/* hw/rtl/piece_bitmap_tracker_assert.svh */
// ----------------------------------------------------------------------------
// Piece bitmap tracker assertion macros
// Assertion helpers used by the tracker controller.
// ----------------------------------------------------------------------------
`ifndef PIECE_BITMAP_TRACKER_ASSERT_SVH
`define PIECE_BITMAP_TRACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PBT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PBT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBT_ASSERT(label, clk, rst, prop, msg)
`define PBT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* hw/rtl/pbt_pkg.sv */
// ----------------------------------------------------------------------------
// Piece bitmap tracker package
// Types, constants and command codes shared by the tracker modules.
// ----------------------------------------------------------------------------
package pbt_pkg;

  // The piece size must be a power of two; piece numbers are taken by shifting.
  localparam int unsigned PIECE_SIZE_DEF     = 1024;
  localparam int unsigned MAX_PIECES_DEF     = 65536;
  localparam int unsigned MAX_RUN_PIECES_DEF = 2048;

  localparam int unsigned SIZE_W   = 27;
  localparam int unsigned OFFSET_W = 26;
  localparam int unsigned LENGTH_W = 22;
  localparam int unsigned COUNT_W  = 17;
  localparam logic [SIZE_W-1:0] FILE_SIZE_RESET = 27'd67108864;

  typedef enum logic [2:0] {
    CMD_MARK_RECEIVED = 3'd0,
    CMD_MARK_MISSING  = 3'd1,
    CMD_QUERY         = 3'd2,
    CMD_FIND          = 3'd3,
    CMD_CLEAR         = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [OFFSET_W-1:0] offset;
  } in_item_t;

  typedef struct packed {
    logic                status;
    logic                piece_received;
    logic                range_found;
    logic [OFFSET_W-1:0] range_offset;
    logic [LENGTH_W-1:0] range_length;
    logic [COUNT_W-1:0]  received_count;
    logic                all_received;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,    // sweep zeros through the bitmap memory
    ST_IDLE,
    ST_RMW,      // read data of a mark/query arrives
    ST_SKIP,     // search: walk past received pieces
    ST_RUN,      // search: count missing pieces
    ST_DONE,     // result formed, waiting for the output transfer
    ST_READ_W,   // wait for a new word read
    ST_WIPE      // clear command: sweep zeros, then report
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic start;      // latch input item, issue first read
    logic clear_step; // write zero to the sweep address
    logic rmw;        // apply mark or query to the read word
    logic scan;       // evaluate one piece of the search
    logic finish;     // build the result
    logic clear_cnt;  // zero the count and sweep address
    logic load_size;  // take a new file size
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_last;
    logic err;         // offset out of range
    logic is_find;
    logic is_clear;    // clear command
    logic scan_done;   // search is finished
    logic scan_next;   // search needs the next word
    logic to_run;      // skip phase found a missing piece
  } dp_stat_t;

endpackage

/* hw/rtl/pbt_ctrl.sv */
// ----------------------------------------------------------------------------
// Piece bitmap tracker controller
// Sequences clearing sweeps, read-modify-write and range search.
// ----------------------------------------------------------------------------
`include "piece_bitmap_tracker_assert.svh"
module pbt_ctrl
  import pbt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_e state, state_next;
  logic   in_run;   // we are inside the search: skip or run phase

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLEAR;
      in_run <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        in_run <= 1'b0;
      end else if (state == ST_SKIP && stat.to_run) begin
        in_run <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (stat.clear_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (cfg_valid) begin
          state_next = ST_CLEAR;
        end else if (in_valid) begin
          state_next = ST_RMW;
        end
      end
      ST_RMW: begin
        if (stat.err) begin
          state_next = ST_DONE;
        end else if (stat.is_find) begin
          state_next = ST_SKIP;
        end else if (stat.is_clear) begin
          state_next = ST_WIPE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SKIP, ST_RUN: begin
        if (stat.scan_done) begin
          state_next = ST_DONE;
        end else if (stat.scan_next) begin
          state_next = ST_READ_W;
        end else if (stat.to_run) begin
          state_next = ST_RUN;
        end
      end
      ST_READ_W: state_next = in_run ? ST_RUN : ST_SKIP;
      ST_WIPE: if (stat.clear_last) state_next = ST_DONE;
      ST_DONE: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cfg_ready = 1'b0;
    case (state)
      ST_CLEAR, ST_WIPE: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        cfg_ready     = 1'b1;
        in_ready      = !cfg_valid;
        cmd.start     = in_valid && !cfg_valid;
        cmd.clear_cnt = cfg_valid;
        cmd.load_size = cfg_valid;
      end
      ST_RMW: begin
        cmd.rmw    = 1'b1;
        cmd.finish = !stat.is_find || stat.err;
      end
      ST_SKIP, ST_RUN: begin
        cmd.scan   = 1'b1;
        cmd.finish = stat.scan_done;
      end
      ST_DONE: out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end

  `PBT_ASSERT(a_no_in_while_busy, clk, rst, (state != ST_IDLE) |-> !in_ready, "in_ready outside idle")
  `PBT_ASSERT(a_done_holds, clk, rst, (out_valid && !out_ready && !cfg_valid) |=> out_valid, "result dropped")
  `PBT_ASSERT(a_excl, clk, rst, !(in_ready && out_valid), "input and output ready together")
  `PBT_ASSERT(a_cfg_idle, clk, rst, cfg_ready |-> (state == ST_IDLE), "config taken while busy")

endmodule

/* hw/rtl/pbt_datapath.sv */
// ----------------------------------------------------------------------------
// Piece bitmap tracker datapath
// Bitmap memory, received count, file size and the range search words.
// ----------------------------------------------------------------------------
module pbt_datapath
  import pbt_pkg::*;
#(
  parameter int unsigned PIECE_SIZE     = PIECE_SIZE_DEF,
  parameter int unsigned MAX_PIECES     = MAX_PIECES_DEF,
  parameter int unsigned MAX_RUN_PIECES = MAX_RUN_PIECES_DEF
)
(
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  in_item_t          in_item,
  input  logic [SIZE_W-1:0] cfg_data,
  output out_item_t         out_item
);

  localparam int unsigned NWORDS   = (MAX_PIECES + 31) / 32;
  localparam int unsigned AW       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned PW       = $clog2(MAX_PIECES + 1) + 1; // piece index width
  localparam int unsigned RW       = $clog2(MAX_RUN_PIECES + 1);
  localparam int unsigned WIDE     = 48;
  localparam int unsigned PL_SHIFT = $clog2(PIECE_SIZE);
  localparam logic [WIDE-1:0] CAP = WIDE'(MAX_PIECES) * WIDE'(PIECE_SIZE);
  localparam logic [WIDE-1:0] PL  = WIDE'(PIECE_SIZE);

  logic [31:0] mem [NWORDS];
  logic [31:0] rdata;
  logic [AW-1:0] raddr;
  logic        we;
  logic [AW-1:0] waddr;
  logic [31:0] wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // File size and derived piece total, recomputed when written.
  logic [WIDE-1:0] size;
  logic [PW-1:0]   pieces;
  logic [SIZE_W-1:0] file_size;
  logic [WIDE-1:0] size_cap;
  logic [WIDE-1:0] piece_calc;

  always_comb begin
    size_cap   = (WIDE'(file_size) > CAP) ? CAP : WIDE'(file_size);
    piece_calc = (size_cap + PL - WIDE'(1)) >> PL_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size <= FILE_SIZE_RESET;
    end else if (cmd.load_size) begin
      file_size <= cfg_data;
    end
    size   <= size_cap;
    pieces <= PW'(piece_calc);
  end

  // Latched item.
  logic [2:0]          c;
  logic [OFFSET_W-1:0] off;
  logic [PW-1:0]       p;     // current piece of the search
  logic [RW-1:0]       n;
  logic [PW-1:0]       start_p;
  logic [COUNT_W-1:0]  count;
  logic [AW:0]         sweep;
  logic                err, rcv, found;
  logic [WIDE-1:0]     roff_w, rlen_w;

  logic [PW-1:0] p_of_off;
  assign p_of_off = PW'(in_item.offset >> PL_SHIFT);

  logic is_rmw, is_find, cmd_err;
  assign is_rmw  = (c == CMD_MARK_RECEIVED) || (c == CMD_MARK_MISSING) || (c == CMD_QUERY);
  assign is_find = (c == CMD_FIND);
  assign cmd_err = (c <= CMD_FIND) && (WIDE'(off) >= size);

  // Search: examine the bits of the current word from p upward.
  logic        bit_now;
  logic [4:0]  bidx;
  logic        in_file;
  assign bidx    = p[4:0];
  assign in_file = (p < pieces) && (p < PW'(MAX_PIECES));
  assign bit_now = in_file ? rdata[bidx] : 1'b1;

  logic skip_phase;
  logic word_end;
  assign word_end = (bidx == 5'd31);

  // Pieces in the run including the one being examined now.
  logic [RW:0] n_final;
  assign n_final = (RW+1)'(n) + ((in_file && !bit_now && (n != RW'(MAX_RUN_PIECES)))
                   ? (RW+1)'(1) : (RW+1)'(0));

  always_comb begin
    stat            = '0;
    stat.clear_last = (sweep == (AW+1)'(NWORDS - 1));
    stat.err        = cmd_err;
    stat.is_find    = is_find;
    stat.is_clear   = (c == CMD_CLEAR);
    if (skip_phase) begin
      stat.scan_done = !in_file;
      stat.to_run    = in_file && !bit_now;
      stat.scan_next = in_file && bit_now && word_end;
    end else begin
      stat.scan_done = !in_file || bit_now || (RW'(n + 1'b1) == RW'(MAX_RUN_PIECES))
                       || (n == RW'(MAX_RUN_PIECES));
      stat.scan_next = !stat.scan_done && word_end;
    end
  end

  logic [31:0] mask;
  assign mask = 32'd1 << bidx;

  always_comb begin
    we    = 1'b0;
    waddr = AW'(sweep);
    wdata = '0;
    raddr = AW'(p >> 5);
    if (cmd.clear_step) begin
      we = 1'b1;
    end else if (cmd.rmw && !cmd_err && c != CMD_QUERY && is_rmw) begin
      we    = 1'b1;
      waddr = AW'(p >> 5);
      wdata = (c == CMD_MARK_RECEIVED) ? (rdata | mask) : (rdata & ~mask);
    end
    if (cmd.start) raddr = AW'(p_of_off >> 5);
    else if (cmd.scan && word_end) raddr = AW'((p + 1'b1) >> 5);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_cnt) begin
      sweep <= '0;
      count <= '0;
    end else begin
      if (cmd.clear_step) sweep <= sweep + 1'b1;
      else sweep <= '0;
      if (cmd.rmw && !cmd_err) begin
        if (c == CMD_CLEAR) begin
          count <= '0;
        end else if (c == CMD_MARK_RECEIVED && !rdata[bidx]) begin
          count <= count + 1'b1;
        end else if (c == CMD_MARK_MISSING && rdata[bidx] && count != '0) begin
          count <= count - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      c   <= in_item.cmd;
      off <= in_item.offset;
      p   <= p_of_off;
      n   <= '0;
      skip_phase <= 1'b1;
    end else if (cmd.scan) begin
      if (skip_phase) begin
        if (in_file && !bit_now) begin
          skip_phase <= 1'b0;
          start_p    <= p;
        end else begin
          p <= p + 1'b1;
        end
      end else if (!stat.scan_done || (in_file && !bit_now)) begin
        p <= p + 1'b1;
        n <= n + 1'b1;
      end
    end
    if (cmd.finish) begin
      err   <= cmd_err;
      rcv   <= 1'b0;
      found <= 1'b0;
      roff_w <= '0;
      rlen_w <= '0;
      if (!cmd_err && c == CMD_QUERY) rcv <= rdata[bidx];
      if (!cmd_err && (c == CMD_MARK_RECEIVED)) rcv <= 1'b1;
      if (!cmd_err && is_find && !skip_phase) begin
        found  <= 1'b1;
        roff_w <= WIDE'(start_p) << PL_SHIFT;
        rlen_w <= (((WIDE'(start_p) + WIDE'(n_final)) << PL_SHIFT) > size)
                  ? size - (WIDE'(start_p) << PL_SHIFT) : (WIDE'(n_final) << PL_SHIFT);
      end
    end
  end

  always_comb begin
    out_item.status         = err;
    out_item.piece_received = rcv;
    out_item.range_found    = found;
    out_item.range_offset   = OFFSET_W'(roff_w);
    out_item.range_length   = LENGTH_W'(rlen_w);
    out_item.received_count = count;
    out_item.all_received   = (PW'(count) >= pieces);
  end

endmodule

/* hw/rtl/piece_bitmap_tracker.sv */
// ----------------------------------------------------------------------------
// Piece bitmap tracker
// Received-piece scoreboard with mark, query, clear and empty-range search.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_ready  in_item_t  (cmd, offset)
// out      output     out_valid/out_ready out_item_t (status .. all_received)
// cfg      input      cfg_valid/cfg_ready file_size, 27 bits
//
// Marks, queries, errors and unknown codes go through accept, one bitmap
// read with the write, then the result transfer; input waits until then.
// A range search adds a step per piece examined, one more when a run of
// missing pieces begins, and a word read wait per bitmap word boundary.
// After reset, after a file_size write and for a clear command the bitmap is
// swept to zero, one word per cycle (2048 words by default); file_size is
// only taken while idle. A stalled output holds the result and blocks input.
// ----------------------------------------------------------------------------
module piece_bitmap_tracker
  import pbt_pkg::*;
#(
  parameter int unsigned PIECE_SIZE     = PIECE_SIZE_DEF,
  parameter int unsigned MAX_PIECES     = MAX_PIECES_DEF,
  parameter int unsigned MAX_RUN_PIECES = MAX_RUN_PIECES_DEF
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pbt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .stat(stat), .cmd(cmd)
  );

  pbt_datapath #(
    .PIECE_SIZE(PIECE_SIZE), .MAX_PIECES(MAX_PIECES),
    .MAX_RUN_PIECES(MAX_RUN_PIECES)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_item(in_data), .cfg_data(cfg_data),
    .out_item(out_data)
  );

endmodule
